/* sv/mac_address_acl_filter_assert.svh */
// Assertion macros shared by the station address filter RTL.
`ifndef MAC_ADDRESS_ACL_FILTER_ASSERT_SVH
`define MAC_ADDRESS_ACL_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MACF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MACF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* sv/macf_pkg.sv */
// Types and constants of the station address filter.
package macf_pkg;

  // Table geometry.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int ADDR_W   = 48;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int POLICY_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Code 3 is unused and rejects every frame.
  typedef enum logic [POLICY_W-1:0] {
    POL_OPEN  = 2'd0,
    POL_ALLOW = 2'd1,
    POL_DENY  = 2'd2
  } policy_e;

endpackage

/* sv/mac_address_acl_filter.sv */
// Station MAC address filter: sequencer, valid bits and address table.
//
// A command beat (operation_i, mac_address_i) is taken at a rising edge with
// start high and busy low. Operations are check, add, remove and flush.
// Each command yields one result beat: done_o is high for exactly one cycle
// with accepted_o, status_o and entry_count_o; the receiver cannot stall it.
// The user must write the policy register with cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this. Check, add and remove
// walk all ENTRIES table slots through one address RAM read port and one
// 48-bit comparator, one slot per cycle, in S_SCAN and then pass S_LAST and
// S_DONE; done_o shows in the cycle after S_DONE, and the next command can
// be taken once busy is low again. A flush goes straight to S_DONE, where
// all valid bits are cleared at once. The slot walk sets the rate.
// Reset clears the valid bits, the held count, the policy (open) and the
// sequencer; the address RAM is not cleared, unlisted slots are never used.
module mac_address_acl_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [macf_pkg::OP_W-1:0]       operation_i,
  input  logic [macf_pkg::ADDR_W-1:0]     mac_address_i,
  input  logic                            cfg_we_i,
  input  logic [macf_pkg::POLICY_W-1:0]   cfg_wdata_i,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [macf_pkg::STATUS_W-1:0]   status_o,
  output logic [macf_pkg::COUNT_W-1:0]    entry_count_o
);

`include "mac_address_acl_filter_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  state_e                         state_q;
  macf_pkg::op_e                  op_q;
  logic [macf_pkg::ADDR_W-1:0]    addr_q;
  logic [macf_pkg::POLICY_W-1:0]  policy_q;
  logic [macf_pkg::ENTRIES-1:0]   valid_q;
  logic [macf_pkg::CNT_W-1:0]     held_count_q;
  logic [macf_pkg::IDX_W-1:0]     scan_idx_q;
  logic [macf_pkg::IDX_W-1:0]     cmp_idx_q;
  logic                           cmp_vld_q;
  logic                           hit_q;
  logic [macf_pkg::IDX_W-1:0]     hit_idx_q;
  logic                           free_found_q;
  logic [macf_pkg::IDX_W-1:0]     free_idx_q;

  logic [macf_pkg::ADDR_W-1:0]    ram_rdata;
  logic                           ram_we;
  logic                           cmp_valid_bit;
  logic                           cmp_hit;
  logic                           cmp_free;
  logic                           table_full;
  logic                           check_accept;
  logic [macf_pkg::CNT_W+macf_pkg::COUNT_W-1:0] count_ext;

  assign busy = (state_q != S_IDLE);

  // Shared comparator: one stored slot against the command address per cycle.
  assign cmp_valid_bit = valid_q[cmp_idx_q];
  assign cmp_hit       = cmp_vld_q && cmp_valid_bit && (ram_rdata == addr_q);
  assign cmp_free      = cmp_vld_q && !cmp_valid_bit;

  assign table_full = (held_count_q == macf_pkg::CNT_W'(macf_pkg::ENTRIES));

  // Policy decision for a check once the walk is over.
  always_comb begin
    case (macf_pkg::policy_e'(policy_q))
      macf_pkg::POL_OPEN:  check_accept = 1'b1;
      macf_pkg::POL_ALLOW: check_accept = hit_q;
      macf_pkg::POL_DENY:  check_accept = !hit_q;
      default:             check_accept = 1'b0;
    endcase
  end

  // A new address lands in the first free slot found by the walk.
  assign ram_we = (state_q == S_DONE) && (op_q == macf_pkg::OP_ADD) &&
                  !table_full && !hit_q;

  assign count_ext = {{macf_pkg::COUNT_W{1'b0}}, held_count_q};

  macf_ram #(
    .WIDTH(macf_pkg::ADDR_W),
    .DEPTH(macf_pkg::ENTRIES)
  ) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i(addr_q),
    .raddr_i(scan_idx_q),
    .rdata_o(ram_rdata)
  );

  // Sequencer, table state and registered result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= macf_pkg::OP_CHECK;
      addr_q        <= '0;
      policy_q      <= macf_pkg::POL_OPEN;
      valid_q       <= '0;
      held_count_q  <= '0;
      scan_idx_q    <= '0;
      cmp_idx_q     <= '0;
      cmp_vld_q     <= 1'b0;
      hit_q         <= 1'b0;
      hit_idx_q     <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      done_o        <= 1'b0;
      accepted_o    <= 1'b0;
      status_o      <= macf_pkg::ST_OK;
      entry_count_o <= '0;
    end else begin
      done_o <= 1'b0;

      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end

      // Record the first match and the first free slot of the walk.
      if (cmp_hit && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end
      if (cmp_free && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q         <= macf_pkg::op_e'(operation_i);
            addr_q       <= mac_address_i;
            scan_idx_q   <= '0;
            cmp_vld_q    <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            if (macf_pkg::op_e'(operation_i) == macf_pkg::OP_FLUSH) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_q  <= 1'b1;
          cmp_idx_q  <= scan_idx_q;
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_idx_q == macf_pkg::IDX_W'(macf_pkg::ENTRIES - 1)) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          cmp_vld_q <= 1'b0;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          state_q       <= S_IDLE;
          done_o        <= 1'b1;
          accepted_o    <= 1'b0;
          status_o      <= macf_pkg::ST_OK;
          entry_count_o <= count_ext[macf_pkg::COUNT_W-1:0];
          case (op_q)
            macf_pkg::OP_CHECK: begin
              accepted_o <= check_accept;
            end
            macf_pkg::OP_ADD: begin
              if (table_full) begin
                status_o <= macf_pkg::ST_FULL;
              end else if (hit_q) begin
                status_o <= macf_pkg::ST_PRESENT;
              end else begin
                valid_q[free_idx_q] <= 1'b1;
                held_count_q        <= held_count_q + 1'b1;
                entry_count_o       <= count_ext[macf_pkg::COUNT_W-1:0] + 1'b1;
              end
            end
            macf_pkg::OP_REMOVE: begin
              if (!hit_q) begin
                status_o <= macf_pkg::ST_ABSENT;
              end else begin
                valid_q[hit_idx_q] <= 1'b0;
                held_count_q       <= held_count_q - 1'b1;
                entry_count_o      <= count_ext[macf_pkg::COUNT_W-1:0] - 1'b1;
              end
            end
            default: begin
              valid_q       <= '0;
              held_count_q  <= '0;
              entry_count_o <= '0;
            end
          endcase
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the table bookkeeping.
  `MACF_ASSERT_NEXT(a_start_makes_busy, start && !busy, busy, "accepted command did not raise busy")
  `MACF_ASSERT_NOW(a_done_when_idle, done_o, !busy, "result beat while sequencer busy")
  `MACF_ASSERT_NOW(a_count_matches, 1'b1, $countones(valid_q) == held_count_q, "held count differs from valid bits")
  `MACF_ASSERT_NOW(a_full_only_when_full, done_o && (status_o == macf_pkg::ST_FULL), table_full, "table full reported below capacity")

endmodule

/* sv/macf_ram.sv */
// Generic simple dual-port RAM with registered read data.
module macf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* tb/sv/mac_address_acl_filter_tb.sv */
// Self-checking testbench of the station MAC address filter with a verdict predictor.
`timescale 1ns / 100ps

module mac_address_acl_filter_tb;

  // Policy code outside the enum; the block rejects every frame under it.
  localparam logic [macf_pkg::POLICY_W-1:0] POL_UNUSED = 2'd3;
  localparam int SLOT_WALK = macf_pkg::ENTRIES + 3;
  localparam int POOL_SIZE = 80;
  localparam int MAX_REPORTS = 10;
  localparam logic [macf_pkg::ADDR_W-1:0] ADDR_ONES = {macf_pkg::ADDR_W{1'b1}};

  // One predicted result beat, with the command that caused it.
  typedef struct {
    macf_pkg::op_e                op;
    logic [macf_pkg::ADDR_W-1:0]  addr;
    logic                         accepted;
    macf_pkg::status_e            status;
    logic [macf_pkg::COUNT_W-1:0] count;
  } verdict_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic [macf_pkg::OP_W-1:0]     operation_i = '0;
  logic [macf_pkg::ADDR_W-1:0]   mac_address_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [macf_pkg::POLICY_W-1:0] cfg_wdata_i = '0;
  logic                          busy;
  logic                          done_o;
  logic                          accepted_o;
  logic [macf_pkg::STATUS_W-1:0] status_o;
  logic [macf_pkg::COUNT_W-1:0]  entry_count_o;

  // Shadow copy of the table and the policy register.
  logic [macf_pkg::ADDR_W-1:0]   shadow_addr [macf_pkg::ENTRIES];
  logic                          shadow_valid [macf_pkg::ENTRIES];
  int                            shadow_count;
  logic [macf_pkg::POLICY_W-1:0] shadow_policy;

  verdict_t                      verdicts_due [$];
  logic [macf_pkg::ADDR_W-1:0]   station_pool [POOL_SIZE];
  int                            idle_pct;
  int                            faults;
  int                            commands_sent;
  int                            results_seen;
  int                            op_tally [4];
  int                            status_tally [4];
  int                            policy_tally [4];

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mac_address_acl_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .mac_address_i (mac_address_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .accepted_o    (accepted_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // Generous run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void note_fault(string msg);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic logic [macf_pkg::ADDR_W-1:0] random_station();
    logic [63:0] r = {$urandom, $urandom};
    return r[macf_pkg::ADDR_W-1:0];
  endfunction

  // Slot that holds the address, or -1 when it is not listed.
  function automatic int find_station(logic [macf_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < macf_pkg::ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the result beat it yields.
  function automatic verdict_t predict_verdict(macf_pkg::op_e op,
                                               logic [macf_pkg::ADDR_W-1:0] addr);
    verdict_t v;
    int       slot;
    v.op       = op;
    v.addr     = addr;
    v.accepted = 1'b0;
    v.status   = macf_pkg::ST_OK;
    case (op)
      macf_pkg::OP_CHECK: begin
        case (shadow_policy)
          macf_pkg::POL_OPEN:  v.accepted = 1'b1;
          macf_pkg::POL_ALLOW: v.accepted = (find_station(addr) >= 0);
          macf_pkg::POL_DENY:  v.accepted = (find_station(addr) < 0);
          default:             v.accepted = 1'b0;
        endcase
      end
      macf_pkg::OP_ADD: begin
        // Fullness wins over the duplicate search.
        slot = -1;
        for (int i = macf_pkg::ENTRIES - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) slot = i;
        end
        if (slot < 0) begin
          v.status = macf_pkg::ST_FULL;
        end else if (find_station(addr) >= 0) begin
          v.status = macf_pkg::ST_PRESENT;
        end else begin
          shadow_addr[slot]  = addr;
          shadow_valid[slot] = 1'b1;
          shadow_count++;
        end
      end
      macf_pkg::OP_REMOVE: begin
        slot = find_station(addr);
        if (slot < 0) begin
          v.status = macf_pkg::ST_ABSENT;
        end else begin
          shadow_valid[slot] = 1'b0;
          shadow_count--;
        end
      end
      default: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        shadow_count = 0;
      end
    endcase
    v.count = macf_pkg::COUNT_W'(shadow_count);
    return v;
  endfunction

  // Checks every result beat against the oldest pending verdict.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        note_fault($sformatf("result beat with nothing pending: acc=%0b st=%0d cnt=%0d",
                             accepted_o, status_o, entry_count_o));
      end else begin
        want = verdicts_due.pop_front();
        if (accepted_o !== want.accepted || status_o !== want.status ||
            entry_count_o !== want.count) begin
          note_fault($sformatf(
            "%s %h: expected acc=%0b st=%s cnt=%0d, got acc=%0b st=%0d cnt=%0d",
            want.op.name(), want.addr, want.accepted, want.status.name(), want.count,
            accepted_o, status_o, entry_count_o));
        end
      end
    end
  end

  // Presents one command beat and returns at the edge that accepts it.
  // The sender holds start low in a random share of cycles given by idle_pct.
  task automatic send_command(macf_pkg::op_e op, logic [macf_pkg::ADDR_W-1:0] addr);
    verdict_t v;
    logic     taken;
    operation_i   <= op;
    mac_address_i <= addr;
    start         <= ($urandom_range(99) >= idle_pct);
    do begin
      @(posedge clk_i);
      taken = start && !busy;
      if (!taken) start <= ($urandom_range(99) >= idle_pct);
    end while (!taken);
    v = predict_verdict(op, addr);
    verdicts_due.push_back(v);
    commands_sent++;
    op_tally[int'(op)]++;
    status_tally[int'(v.status)]++;
    if (op == macf_pkg::OP_CHECK) policy_tally[int'(shadow_policy)]++;
  endtask

  // Writes the policy register once the block has drained.
  task automatic write_policy(logic [macf_pkg::POLICY_W-1:0] value);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    shadow_policy = value;
  endtask

  task automatic test_open_after_reset();
    send_command(macf_pkg::OP_CHECK, '0);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
    send_command(macf_pkg::OP_FLUSH, ADDR_ONES);
  endtask

  task automatic test_add_remove();
    send_command(macf_pkg::OP_ADD, '0);
    send_command(macf_pkg::OP_ADD, ADDR_ONES);
    send_command(macf_pkg::OP_ADD, '0);
    send_command(macf_pkg::OP_REMOVE, 48'h0000_0000_0001);
    send_command(macf_pkg::OP_REMOVE, ADDR_ONES);
    send_command(macf_pkg::OP_REMOVE, ADDR_ONES);
    send_command(macf_pkg::OP_ADD, 48'h8000_0000_0000);
  endtask

  // Allow, deny and the unused code each against a listed and an unlisted station, then open.
  task automatic test_policy_modes();
    write_policy(macf_pkg::POL_ALLOW);
    send_command(macf_pkg::OP_CHECK, '0);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
    write_policy(macf_pkg::POL_DENY);
    send_command(macf_pkg::OP_CHECK, '0);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
    write_policy(POL_UNUSED);
    send_command(macf_pkg::OP_CHECK, '0);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
    write_policy(macf_pkg::POL_OPEN);
    send_command(macf_pkg::OP_CHECK, 48'h5555_aaaa_5555);
  endtask

  // Fills the table, adds a listed and a fresh station to the full table, then frees a slot and refills it.
  task automatic test_table_full();
    logic [macf_pkg::ADDR_W-1:0] first;
    first = random_station();
    send_command(macf_pkg::OP_FLUSH, random_station());
    send_command(macf_pkg::OP_ADD, first);
    for (int i = 1; i < macf_pkg::ENTRIES; i++) begin
      send_command(macf_pkg::OP_ADD, random_station());
    end
    send_command(macf_pkg::OP_ADD, first);
    send_command(macf_pkg::OP_ADD, random_station());
    send_command(macf_pkg::OP_REMOVE, first);
    send_command(macf_pkg::OP_ADD, ADDR_ONES);
    send_command(macf_pkg::OP_ADD, first);
    write_policy(macf_pkg::POL_ALLOW);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
    send_command(macf_pkg::OP_FLUSH, '0);
    send_command(macf_pkg::OP_CHECK, ADDR_ONES);
  endtask

  // Mostly pool addresses so that adds, removes and checks hit listed entries.
  task automatic test_random_traffic(int items, logic [macf_pkg::POLICY_W-1:0] policy);
    int                          r;
    macf_pkg::op_e               op;
    logic [macf_pkg::ADDR_W-1:0] addr;
    foreach (station_pool[i]) station_pool[i] = random_station();
    station_pool[0] = '0;
    station_pool[1] = ADDR_ONES;
    write_policy(policy);
    for (int n = 0; n < items; n++) begin
      if (n % 60 == 59) write_policy(macf_pkg::POLICY_W'($urandom_range(3)));
      r = $urandom_range(99);
      if (r < 3) op = macf_pkg::OP_FLUSH;
      else if (r < 45) op = macf_pkg::OP_ADD;
      else if (r < 68) op = macf_pkg::OP_REMOVE;
      else op = macf_pkg::OP_CHECK;
      if ($urandom_range(99) < 85) addr = station_pool[$urandom_range(POOL_SIZE - 1)];
      else addr = random_station();
      send_command(op, addr);
    end
  endtask

  // Reset, directed tests, then random traffic under three sender profiles.
  initial begin
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    shadow_count  = 0;
    shadow_policy = macf_pkg::POL_OPEN;
    idle_pct      = 26;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_open_after_reset();
    test_add_remove();
    test_policy_modes();
    test_table_full();
    test_random_traffic(200, macf_pkg::POL_ALLOW);
    idle_pct = 74;
    test_random_traffic(200, macf_pkg::POL_DENY);
    idle_pct = 0;
    test_random_traffic(180, POL_UNUSED);

    // Drain, with a limit, then allow one slot walk for stray beats.
    start <= 1'b0;
    for (int n = 0; n < 4 * SLOT_WALK && verdicts_due.size() != 0; n++) @(posedge clk_i);
    repeat (SLOT_WALK + 8) @(posedge clk_i);
    foreach (verdicts_due[i]) begin
      note_fault($sformatf("no result for %s %h", verdicts_due[i].op.name(),
                           verdicts_due[i].addr));
    end

    $display("Sent %0d commands (check %0d, add %0d, remove %0d, flush %0d), %0d results.",
             commands_sent, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
             results_seen);
    $display("Statuses ok/present/absent/full: %0d/%0d/%0d/%0d; checks per policy: %0d/%0d/%0d/%0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             policy_tally[0], policy_tally[1], policy_tally[2], policy_tally[3]);
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
